// ===== hw/rtl/percent_escape_decoder_defines.svh =====
// Assertion macros used by the percent escape decoder checker.
`ifndef PERCENT_ESCAPE_DECODER_DEFINES_SVH
`define PERCENT_ESCAPE_DECODER_DEFINES_SVH

// Checked at every clock edge, reset included.
`define PED_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) (expr)) else $error(msg);

// Checked only while reset is released.
`define PED_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== hw/rtl/ped_pkg.sv =====
// Types, constants and the hex digit helper of the percent escape decoder.
`timescale 1ns / 1ps

package ped_pkg;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam logic [7:0] LOWER_BIAS   = 8'd87;
    localparam logic [7:0] UPPER_BIAS   = 8'd55;
    localparam logic [7:0] DIGIT_BIAS   = 8'd48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [2:0] {
        PHASE_PLAIN   = 3'b001,
        PHASE_PERCENT = 3'b010,
        PHASE_HIGH    = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       end_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_out_t;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h61 && c <= 8'h66)
            v = c - LOWER_BIAS;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - UPPER_BIAS;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c - DIGIT_BIAS;
        return v[3:0];
    endfunction

endpackage

// ===== hw/rtl/ped_in_if.sv =====
// Input channel of the percent escape decoder: one raw byte per transfer.
`timescale 1ns / 1ps

interface ped_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_final;

    modport source (output valid, output char_in, output is_final, input ready);
    modport sink (input valid, input char_in, input is_final, output ready);
endinterface

// ===== hw/rtl/ped_out_if.sv =====
// Output channel of the percent escape decoder: one decoded byte per transfer.
`timescale 1ns / 1ps

interface ped_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       end_of_run;

    modport source (output valid, output byte_out, output end_of_run, input ready);
    modport sink (input valid, input byte_out, input end_of_run, output ready);
endinterface

// ===== hw/rtl/ped_decode.sv =====
// Escape phase register and the per-byte decode into up to two results.
`timescale 1ns / 1ps

module ped_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [7:0]        char_in,
    input  logic              is_final,
    output ped_pkg::dec_out_t dec
);
    import ped_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] high_reg;
    logic [3:0] high_next;
    dec_out_t   dec_raw;

    always_comb
    begin
        phase_next     = PHASE_PLAIN;
        high_next      = 4'd0;
        dec_raw.count  = 2'd1;
        dec_raw.first  = '{byte_out: char_in, end_of_run: is_final};
        dec_raw.second = '{byte_out: char_in, end_of_run: 1'b1};
        unique case (phase_reg)
            PHASE_PERCENT:
            begin
                if (is_final)
                begin
                    dec_raw.count = 2'd2;
                    dec_raw.first = '{byte_out: PERCENT_CHAR, end_of_run: 1'b0};
                end
                else
                begin
                    dec_raw.count = 2'd0;
                    high_next     = digit_value(char_in);
                    phase_next    = PHASE_HIGH;
                end
            end
            PHASE_HIGH:
            begin
                dec_raw.first.byte_out = {high_reg, digit_value(char_in)};
            end
            default:
            begin
                if (char_in == PERCENT_CHAR && !is_final)
                begin
                    dec_raw.count = 2'd0;
                    phase_next    = PHASE_PERCENT;
                end
            end
        endcase
    end

    always_comb
    begin
        dec = dec_raw;
        if (!go)
            dec.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_PLAIN;
            high_reg  <= 4'd0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
        end
    end
endmodule

// ===== hw/rtl/ped_out_queue.sv =====
// Four-entry result queue that takes up to two results and gives one per cycle while the output is ready.
`timescale 1ns / 1ps

module ped_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ped_pkg::dec_out_t dec,
    output logic              has_room,
    ped_out_if.source         out_ch
);
    import ped_pkg::*;

    result_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0]   wr_ptr_reg;
    logic [QUEUE_IDX_W-1:0]   wr_ptr_next;
    logic [QUEUE_IDX_W-1:0]   rd_ptr_reg;
    logic [QUEUE_IDX_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic [QUEUE_IDX_W-1:0]   wr_ptr_plus1;
    logic                     pop;

    assign has_room     = count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign pop          = out_ch.valid && out_ch.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_IDX_W'(1);

    assign out_ch.valid      = count_reg != '0;
    assign out_ch.byte_out   = mem_reg[rd_ptr_reg].byte_out;
    assign out_ch.end_of_run = mem_reg[rd_ptr_reg].end_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_IDX_W'(dec.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_IDX_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(dec.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (dec.count != 2'd0)
            mem_reg[wr_ptr_reg] <= dec.first;
        if (dec.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= dec.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== hw/rtl/percent_escape_decoder.sv =====
// Top level of the streaming percent escape decoder.
// Each input transfer carries one byte of an escaped string, with is_final on its last
// byte; each output transfer carries one decoded byte, with end_of_run on the last byte
// of the string. A byte is taken every cycle while the result queue has room. It is
// decoded while it sits in the input register, and its results are written into the
// result queue as it leaves that register. A final byte right after a percent sign
// yields two results; the four-entry result queue takes both at once and the input
// stalls only while the queue holds more than two results.
`timescale 1ns / 1ps

module percent_escape_decoder (
    input  logic      clk,
    input  logic      rst_n,
    ped_in_if.sink    in_ch,
    ped_out_if.source out_ch
);
    import ped_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] char_reg;
    logic       final_reg;
    logic       has_room;
    logic       dec_go;
    logic       take;
    dec_out_t   dec;

    assign dec_go      = in_valid_reg && has_room;
    assign in_ch.ready = !in_valid_reg || dec_go;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (dec_go)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg  <= in_ch.char_in;
            final_reg <= in_ch.is_final;
        end
    end

    ped_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (dec_go),
        .char_in  (char_reg),
        .is_final (final_reg),
        .dec      (dec)
    );

    ped_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .dec      (dec),
        .has_room (has_room),
        .out_ch   (out_ch)
    );
endmodule

// ===== hw/rtl/ped_checker.sv =====
// Port-level checks of the percent escape decoder and their binding to the top level.
`timescale 1ns / 1ps
`include "percent_escape_decoder_defines.svh"

module ped_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] byte_out,
    input logic       end_of_run
);
    `PED_ASSERT_ALWAYS(a_no_output_in_reset, !rst_n |-> !out_valid, "output valid during reset")
    `PED_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(byte_out) && $stable(end_of_run)), "stalled output changed")
    `PED_ASSERT(a_result_has_source, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without an input transfer")
    `PED_ASSERT(a_stall_only_when_full, !in_ready |-> out_valid, "input stalled with no pending result")
endmodule

bind percent_escape_decoder ped_checker u_ped_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .byte_out   (out_ch.byte_out),
    .end_of_run (out_ch.end_of_run)
);

// ===== test/percent_escape_decoder_test.sv =====
// Testbench of the percent escape decoder: directed and random strings, checked byte by byte.
`timescale 1ns / 1ps

module percent_escape_decoder_test;
    import ped_pkg::*;

    logic clk;
    logic rst_n;

    ped_in_if in_bus ();
    ped_out_if out_bus ();

    percent_escape_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    result_t decoded_due[$];
    phase_t  escape_state;
    logic [3:0] high_digit;

    int mismatches;
    int chars_sent;
    bit sender_steady;
    bit receiver_steady;
    int receiver_hold;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c inside {[8'h30 : 8'h39]})
            return c[3:0];
        if (c inside {[8'h41 : 8'h46], [8'h61 : 8'h66]})
            return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic last);
        result_t r;
        r.byte_out = b;
        r.end_of_run = last;
        decoded_due = {decoded_due, r};
    endfunction

    function automatic void decode_step(input logic [7:0] c, input logic fin);
        case (escape_state)
            PHASE_PERCENT:
            begin
                if (fin)
                begin
                    emit_byte(PERCENT_CHAR, 1'b0);
                    emit_byte(c, 1'b1);
                    escape_state = PHASE_PLAIN;
                    high_digit = 4'd0;
                end
                else
                begin
                    high_digit = nibble_of(c);
                    escape_state = PHASE_HIGH;
                end
            end
            PHASE_HIGH:
            begin
                emit_byte({high_digit, nibble_of(c)}, fin);
                escape_state = PHASE_PLAIN;
                high_digit = 4'd0;
            end
            default:
            begin
                if (c == PERCENT_CHAR && !fin)
                    escape_state = PHASE_PERCENT;
                else
                begin
                    emit_byte(c, fin);
                    escape_state = PHASE_PLAIN;
                end
                high_digit = 4'd0;
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch in %s: expected %0h, actual %0h", what, want, got);
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'h30 + v[7:0];
        if ($urandom_range(0, 1) == 1)
            return 8'h41 + v[7:0] - 8'd10;
        return 8'h61 + v[7:0] - 8'd10;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.char_in <= c;
        in_bus.is_final <= fin;
        do
            @(posedge clk);
        while (!in_bus.ready);
        decode_step(c, fin);
        chars_sent++;
    endtask

    task automatic send_random_string(input int len);
        logic [7:0] text[$];
        int kind;
        while (text.size() < len)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                text = {text, 8'($urandom_range(0, 255))};
            else if (kind < 8)
            begin
                text = {text, PERCENT_CHAR};
                text = {text, hex_char()};
                text = {text, hex_char()};
            end
            else if (kind == 8)
            begin
                text = {text, PERCENT_CHAR};
                text = {text, 8'($urandom_range(0, 255))};
                text = {text, 8'($urandom_range(0, 255))};
            end
            else
                text = {text, PERCENT_CHAR};
        end
        for (int i = 0; i < len; i++)
            send_char(text[i], i == len - 1);
    endtask

    task automatic test_plain_bytes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h55, 1'b0);
        send_char(8'hAA, 1'b1);
        send_char(8'h41, 1'b1);
    endtask

    task automatic test_escape_sequences();
        send_char(PERCENT_CHAR, 1'b0);
        send_char(8'h34, 1'b0);
        send_char(8'h31, 1'b0);
        send_char(PERCENT_CHAR, 1'b0);
        send_char(8'h66, 1'b0);
        send_char(8'h46, 1'b0);
        // Neither byte is a hex digit, so both count as zero.
        send_char(PERCENT_CHAR, 1'b0);
        send_char(8'h7A, 1'b0);
        send_char(PERCENT_CHAR, 1'b0);
        // The low digit is the final byte and closes the string.
        send_char(PERCENT_CHAR, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h37, 1'b1);
    endtask

    task automatic test_truncated_escapes();
        send_char(PERCENT_CHAR, 1'b1);
        send_char(PERCENT_CHAR, 1'b0);
        send_char(PERCENT_CHAR, 1'b1);
        send_char(PERCENT_CHAR, 1'b0);
        send_char(8'h39, 1'b1);
    endtask

    task automatic test_backpressure();
        receiver_hold = 60;
        sender_steady = 1'b1;
        repeat (6) send_random_string(8);
        sender_steady = 1'b0;
    endtask

    task automatic test_steady_flow();
        sender_steady = 1'b1;
        receiver_steady = 1'b1;
        repeat (12) send_random_string($urandom_range(1, 16));
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic test_random_strings();
        while (chars_sent < 1850)
            send_random_string($urandom_range(1, 12));
    endtask

    initial
    begin
        int drain_cycles;
        rst_n <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.char_in <= 8'h00;
        in_bus.is_final <= 1'b0;
        escape_state = PHASE_PLAIN;
        high_digit = 4'd0;
        mismatches = 0;
        chars_sent = 0;
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        receiver_hold = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_escape_sequences();
        test_truncated_escapes();
        test_backpressure();
        test_steady_flow();
        test_random_strings();

        in_bus.valid <= 1'b0;
        drain_cycles = 0;
        while (decoded_due.size() != 0 && drain_cycles < 10000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0 && decoded_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (receiver_hold > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (receiver_hold) @(posedge clk);
                receiver_hold = 0;
            end
            stall = receiver_steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (decoded_due.size() == 0)
                note_mismatch("unexpected transfer", 0,
                              {out_bus.byte_out, out_bus.end_of_run});
            else
            begin
                want = decoded_due.pop_front();
                if (out_bus.byte_out !== want.byte_out)
                    note_mismatch("byte_out", want.byte_out, out_bus.byte_out);
                if (out_bus.end_of_run !== want.end_of_run)
                    note_mismatch("end_of_run", want.end_of_run, out_bus.end_of_run);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ped_pkg.sv
hw/rtl/ped_in_if.sv
hw/rtl/ped_out_if.sv
hw/rtl/ped_decode.sv
hw/rtl/ped_out_queue.sv
hw/rtl/percent_escape_decoder.sv
hw/rtl/ped_checker.sv
test/percent_escape_decoder_test.sv
